### rtl/multi_dfa_lexer_core_macros.svh
// assertion macros for the multi-pattern dfa lexer
// used by multi_dfa_lexer_core; needs clk_i and rst_ni in scope
`ifndef MULTI_DFA_LEXER_CORE_MACROS_SVH
`define MULTI_DFA_LEXER_CORE_MACROS_SVH

// clocked assertion, off during reset
`define MDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define MDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/mdl_pkg.sv
// shared types and constants of the multi-pattern dfa lexer
// no dependencies
`timescale 1ns / 1ps

package mdl_pkg;

  localparam int NUM_UNITS   = 8;
  localparam int NUM_STATES  = 64;
  localparam int NUM_CLASSES = 32;
  localparam int MAX_LENGTH  = 4095;

  localparam int UNIT_W  = 3;
  localparam int STATE_W = 6;
  localparam int CLASS_W = 5;
  localparam int LEN_W   = 12;
  localparam int VAL_W   = 7;
  localparam int STEP_W  = $clog2(NUM_UNITS + 2);

  localparam int CMAP_DEPTH  = NUM_UNITS * 256;
  localparam int TRANS_DEPTH = NUM_UNITS * NUM_STATES * NUM_CLASSES;
  localparam int FLAG_DEPTH  = NUM_UNITS * NUM_STATES;

  typedef enum logic [1:0] {
    OP_FEED  = 2'd0,
    OP_CMAP  = 2'd1,
    OP_TRANS = 2'd2,
    OP_FINAL = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    TS_MATCH   = 2'd0,
    TS_NOMATCH = 2'd1,
    TS_EOI     = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADV,
    S_ADV_END,
    S_FLAG,
    S_FLAGD,
    S_PUSH_TOK,
    S_PUSH_EOI,
    S_PUSH_NOM
  } state_e;

  // what follows the pending token result
  typedef enum logic [1:0] {
    AFT_NONE,
    AFT_EOI,
    AFT_START,
    AFT_NOM
  } after_e;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;

endpackage

### rtl/multi_dfa_lexer_core.sv
// multi-pattern dfa lexer: sequencer, unit state and output register
// depends on mdl_pkg, mdl_ram and multi_dfa_lexer_core_macros.svh
`timescale 1ns / 1ps

// Table writes (class map, transition, final flag) go straight to the rams.
// A fed byte steps all NUM_UNITS pattern dfas through one shared lookup
// pipeline: class map read, then transition read, one unit entering per
// cycle. Closing a token adds a final flag read and a push per result; a
// killing byte that restarts a token costs two dfa passes. The output
// register lets the next item be accepted while a result waits, but a
// second result of the same item waits for the first to be taken.
module multi_dfa_lexer_core
  import mdl_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic [UNIT_W-1:0]         pattern_unit_i,
  input  logic [7:0]                char_value_i,
  input  logic [STATE_W-1:0]        state_index_i,
  input  logic [CLASS_W-1:0]        class_index_i,
  input  logic signed [VAL_W-1:0]   table_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                token_status_o,
  output logic [UNIT_W-1:0]         matched_unit_o,
  output logic [LEN_W-1:0]          token_length_o,
  output logic                      last_result_o
);

`include "multi_dfa_lexer_core_macros.svh"

  state_e state_q, state_d;
  after_e after_q;

  logic [NUM_UNITS-1:0] alive_q, nalive_q;
  logic [STATE_W-1:0]   ustate_q [NUM_UNITS];
  logic [STATE_W-1:0]   nstate_q [NUM_UNITS];
  logic                 in_token_q, start_q, any_q, tv_q, tok_pend_q;
  logic [LEN_W-1:0]     len_q, tok_len_q;
  logic [STEP_W-1:0]    step_q;
  logic [7:0]           byte_q;
  logic [1:0]           tok_status_q;
  logic [UNIT_W-1:0]    tok_unit_q;

  logic                 out_valid_q, out_last_q;
  logic [1:0]           out_status_q;
  logic [UNIT_W-1:0]    out_unit_q;
  logic [LEN_W-1:0]     out_len_q;

  logic accept, out_free, out_push, is_space;
  logic [UNIT_W-1:0]  u1, u2, low_u, sel_u;
  logic               low_any;
  logic [STATE_W-1:0] sel_state;

  logic cmap_we, trans_we, flag_we, cmap_re, trans_re, flag_re;
  logic [VAL_W-1:0] cmap_rdata, trans_rdata;
  logic             flag_rdata;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_push = out_free && (state_q inside {S_PUSH_TOK, S_PUSH_EOI, S_PUSH_NOM});
  assign is_space = (char_value_i == CH_SPACE) || (char_value_i == CH_NL) ||
                    (char_value_i == CH_TAB);
  assign u1 = UNIT_W'(step_q - STEP_W'(1));
  assign u2 = UNIT_W'(step_q - STEP_W'(2));

  // lowest live pattern
  always_comb begin
    low_u   = '0;
    low_any = 1'b0;
    for (int i = NUM_UNITS - 1; i >= 0; i--) begin
      if (alive_q[i]) begin
        low_u   = UNIT_W'(i);
        low_any = 1'b1;
      end
    end
  end

  assign sel_u     = (state_q == S_FLAG) ? low_u : u1;
  assign sel_state = start_q ? '0 : ustate_q[sel_u];

  assign cmap_we  = accept && (opcode_i == OP_CMAP);
  assign trans_we = accept && (opcode_i == OP_TRANS);
  assign flag_we  = accept && (opcode_i == OP_FINAL);
  assign cmap_re  = (state_q == S_ADV) && (step_q < STEP_W'(NUM_UNITS));
  assign trans_re = (state_q == S_ADV) && (step_q >= STEP_W'(1)) &&
                    (step_q <= STEP_W'(NUM_UNITS));
  assign flag_re  = (state_q == S_FLAG);

  mdl_ram #(.WIDTH(VAL_W), .DEPTH(CMAP_DEPTH)) u_cmap (
    .clk_i   (clk_i),
    .we_i    (cmap_we),
    .waddr_i ({pattern_unit_i, char_value_i}),
    .wdata_i (table_value_i),
    .re_i    (cmap_re),
    .raddr_i ({UNIT_W'(step_q), byte_q}),
    .rdata_o (cmap_rdata)
  );

  mdl_ram #(.WIDTH(VAL_W), .DEPTH(TRANS_DEPTH)) u_trans (
    .clk_i   (clk_i),
    .we_i    (trans_we),
    .waddr_i ({pattern_unit_i, state_index_i, class_index_i}),
    .wdata_i (table_value_i),
    .re_i    (trans_re),
    .raddr_i ({u1, sel_state, cmap_rdata[CLASS_W-1:0]}),
    .rdata_o (trans_rdata)
  );

  mdl_ram #(.WIDTH(1), .DEPTH(FLAG_DEPTH)) u_flag (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i ({pattern_unit_i, state_index_i}),
    .wdata_i (table_value_i != '0),
    .re_i    (flag_re),
    .raddr_i ({low_u, sel_state}),
    .rdata_o (flag_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (opcode_i == OP_FEED)) begin
          if (!in_token_q) begin
            if (char_value_i == 8'd0) begin
              state_d = S_PUSH_EOI;
            end else if (!is_space) begin
              state_d = S_ADV;
            end
          end else if ((char_value_i == 8'd0) || is_space) begin
            state_d = S_FLAG;
          end else begin
            state_d = S_ADV;
          end
        end
      end
      S_ADV: begin
        if (step_q == STEP_W'(NUM_UNITS + 1)) begin
          state_d = S_ADV_END;
        end
      end
      S_ADV_END: begin
        if (any_q) begin
          state_d = tok_pend_q ? S_PUSH_TOK : S_IDLE;
        end else if (!start_q) begin
          state_d = S_FLAG;
        end else begin
          state_d = tok_pend_q ? S_PUSH_TOK : S_PUSH_NOM;
        end
      end
      S_FLAG:  state_d = S_FLAGD;
      S_FLAGD: state_d = (after_q == AFT_START) ? S_ADV : S_PUSH_TOK;
      S_PUSH_TOK: begin
        if (out_free) begin
          case (after_q)
            AFT_EOI: state_d = S_PUSH_EOI;
            AFT_NOM: state_d = S_PUSH_NOM;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_PUSH_EOI, S_PUSH_NOM: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = (state_q == S_IDLE);
    out_valid_o    = out_valid_q;
    token_status_o = out_status_q;
    matched_unit_o = out_unit_q;
    token_length_o = out_len_q;
    last_result_o  = out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      after_q     <= AFT_NONE;
      alive_q     <= '0;
      in_token_q  <= 1'b0;
      start_q     <= 1'b0;
      any_q       <= 1'b0;
      tok_pend_q  <= 1'b0;
      len_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_UNITS; i++) begin
        ustate_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          byte_q     <= char_value_i;
          step_q     <= '0;
          any_q      <= 1'b0;
          start_q    <= !in_token_q;
          tok_pend_q <= 1'b0;
          after_q    <= (char_value_i == 8'd0) ? AFT_EOI :
                        (is_space ? AFT_NONE : AFT_START);
        end
        S_ADV: begin
          if (step_q != STEP_W'(NUM_UNITS + 1)) begin
            step_q <= step_q + STEP_W'(1);
          end
          if (step_q >= STEP_W'(1) && step_q <= STEP_W'(NUM_UNITS)) begin
            tv_q <= (start_q || alive_q[u1]) && (cmap_rdata[VAL_W-1:CLASS_W] == '0);
          end
          if (step_q >= STEP_W'(2)) begin
            nalive_q[u2] <= tv_q && !trans_rdata[VAL_W-1];
            nstate_q[u2] <= trans_rdata[STATE_W-1:0];
            if (tv_q && !trans_rdata[VAL_W-1]) begin
              any_q <= 1'b1;
            end
          end
        end
        S_ADV_END: begin
          if (any_q) begin
            alive_q    <= nalive_q;
            in_token_q <= 1'b1;
            for (int i = 0; i < NUM_UNITS; i++) begin
              ustate_q[i] <= nstate_q[i];
            end
            if (start_q) begin
              len_q <= LEN_W'(1);
            end else if (len_q < LEN_W'(MAX_LENGTH)) begin
              len_q <= len_q + LEN_W'(1);
            end
            after_q <= AFT_NONE;
          end else if (!start_q) begin
            after_q <= AFT_START;
          end else begin
            after_q <= AFT_NOM;
          end
        end
        S_FLAGD: begin
          tok_status_q <= (low_any && flag_rdata) ? TS_MATCH : TS_NOMATCH;
          tok_unit_q   <= (low_any && flag_rdata) ? low_u : '0;
          tok_len_q    <= len_q;
          tok_pend_q   <= 1'b1;
          in_token_q   <= 1'b0;
          alive_q      <= '0;
          len_q        <= '0;
          start_q      <= 1'b1;
          step_q       <= '0;
          any_q        <= 1'b0;
        end
        S_PUSH_TOK: begin
          if (out_free) begin
            out_status_q <= tok_status_q;
            out_unit_q   <= tok_unit_q;
            out_len_q    <= tok_len_q;
            out_last_q   <= (after_q == AFT_NONE);
          end
        end
        S_PUSH_EOI, S_PUSH_NOM: begin
          if (out_free) begin
            out_status_q <= (state_q == S_PUSH_EOI) ? TS_EOI : TS_NOMATCH;
            out_unit_q   <= '0;
            out_len_q    <= (state_q == S_PUSH_EOI) ? '0 : LEN_W'(1);
            out_last_q   <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `MDL_ASSERT(a_busy_in_pass, (state_q == S_ADV) |-> !in_ready_o, "ready during dfa pass")
  `MDL_ASSERT(a_start_len, (state_q == S_ADV_END && start_q && any_q) |=> (in_token_q && len_q == LEN_W'(1)), "new token length not one")
  `MDL_ASSERT(a_eoi_last, (state_q == S_PUSH_EOI && out_free) |=> (out_valid_o && last_result_o && token_status_o == TS_EOI), "end of input result wrong")
  `MDL_ASSERT(a_step_range, step_q <= STEP_W'(NUM_UNITS + 1), "step counter overrun")
  `MDL_ASSERT_ALWAYS(a_token_live, (in_token_q && rst_ni) |-> (alive_q != '0), "open token with no live pattern")

endmodule

### rtl/mdl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
